### hdl/rate_limited_valve_actuator_macros.svh
// assertion macros used by the checker file
`ifndef RATE_LIMITED_VALVE_ACTUATOR_MACROS_SVH
`define RATE_LIMITED_VALVE_ACTUATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RLVA_ASSERT_COMB(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlva check failed");

// next-cycle implication, disabled while in reset
`define RLVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlva check failed");

`endif

### hdl/rlva_pkg.sv
`default_nettype none

package rlva_pkg;

    localparam int FRAC_BITS  = 15;
    localparam int POS_W      = 16;
    localparam int PRES_W     = 24;
    localparam int DATA_W     = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // fixed-point one, fully open
    localparam logic [POS_W-1:0] ONE = POS_W'(32'd1 << FRAC_BITS);

    localparam logic [POS_W-1:0]  INIT_POS_RESET = '0;
    localparam logic [POS_W-1:0]  STEP_RESET     = POS_W'(328);
    localparam logic [PRES_W-1:0] MIN_PRES_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_POS = 2'd0,
        CFG_STEP     = 2'd1,
        CFG_MIN_PRES = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]  given_position;
        logic              hold_setpoint;
        logic [PRES_W-1:0] inlet_pressure;
        logic [POS_W-1:0]  resistance_in;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [PRES_W-1:0] outlet_pressure;
        logic [POS_W-1:0]  resistance_out;
        logic              setpoint_error;
    } result_t;

    typedef struct packed {
        logic             update;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] setpoint;
    } state_upd_t;

    function automatic logic [POS_W-1:0] sat_one(input logic [POS_W-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

endpackage

`default_nettype wire

### hdl/rate_limited_valve_actuator.sv
`default_nettype none

// channel  | dir | handshake               | payload
// ---------+-----+-------------------------+------------------------------------------
// s_axis   | in  | s_tvalid / s_tready     | s_tdata: given_position, inlet_pressure,
//          |     |                         |   resistance_in; s_tuser: hold_setpoint
// m_axis   | out | m_tvalid / m_tready     | m_tdata: position, outlet_pressure,
//          |     |                         |   resistance_out; m_tuser: setpoint_error
// cfg      | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one transaction per cycle sustained while m_tready takes each result; from input to result:
// (input register, then one pass of step logic into the result register)
// the position and setpoint registers are updated in the same cycle the item
// leaves the input register, so the next item sees the new state directly
// rst_n clears both valid flags and loads the register reset values
// a stalled result holds the result register; the input register still fills only while empty
// cfg_ready is always high; an initial_position write reloads position and setpoint
module rate_limited_valve_actuator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // slave side
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [15:0] given_position, [39:16] inlet_pressure, [55:40] resistance_in
    input  wire logic [rlva_pkg::DATA_W-1:0]        s_tdata,
    // [0] hold_setpoint
    input  wire logic                               s_tuser,
    // master side
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [15:0] position, [39:16] outlet_pressure, [55:40] resistance_out
    output logic [rlva_pkg::DATA_W-1:0]             m_tdata,
    // [0] setpoint_error
    output logic                                    m_tuser,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rlva_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rlva_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int POS_W  = rlva_pkg::POS_W;
    localparam int PRES_W = rlva_pkg::PRES_W;

    // configuration registers
    logic [POS_W-1:0]  init_pos_reg;
    logic [POS_W-1:0]  step_reg;
    logic [PRES_W-1:0] min_pres_reg;

    // actuator state
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  setpoint_reg;

    // pipeline registers
    logic              in_valid_reg;
    rlva_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    rlva_pkg::result_t out_result_reg;

    rlva_pkg::item_t      in_item;
    rlva_pkg::result_t    step_result;
    rlva_pkg::state_upd_t step_upd;

    logic out_free;
    logic step_fire;
    logic cfg_fire;

    // unpack the incoming transaction
    assign in_item.given_position = s_tdata[15:0];
    assign in_item.inlet_pressure = s_tdata[39:16];
    assign in_item.resistance_in  = s_tdata[55:40];
    assign in_item.hold_setpoint  = s_tuser;

    // result register can take a new value when empty or being drained
    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    rlva_step u_step (
        .item         (in_item_reg),
        .cur_pos      (pos_reg),
        .cur_setpoint (setpoint_reg),
        .step         (step_reg),
        .min_pres     (min_pres_reg),
        .result       (step_result),
        .upd          (step_upd)
    );

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item;
        end
    end

    // result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_result_reg <= step_result;
        end
    end

    // configuration and actuator state; writes must only arrive while idle, not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_pos_reg <= rlva_pkg::INIT_POS_RESET;
            step_reg     <= rlva_pkg::STEP_RESET;
            min_pres_reg <= rlva_pkg::MIN_PRES_RESET;
            pos_reg      <= rlva_pkg::sat_one(rlva_pkg::INIT_POS_RESET);
            setpoint_reg <= rlva_pkg::sat_one(rlva_pkg::INIT_POS_RESET);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                rlva_pkg::CFG_INIT_POS:
                begin
                    init_pos_reg <= cfg_data[POS_W-1:0];
                    pos_reg      <= rlva_pkg::sat_one(cfg_data[POS_W-1:0]);
                    setpoint_reg <= rlva_pkg::sat_one(cfg_data[POS_W-1:0]);
                end
                rlva_pkg::CFG_STEP:
                begin
                    step_reg <= cfg_data[POS_W-1:0];
                end
                rlva_pkg::CFG_MIN_PRES:
                begin
                    min_pres_reg <= cfg_data[PRES_W-1:0];
                end
                default:
                begin
                    // unknown register index, write dropped
                    init_pos_reg <= init_pos_reg;
                end
            endcase
        end
        else if (step_fire && step_upd.update)
        begin
            // an out-of-range setpoint leaves the state alone
            pos_reg      <= step_upd.position;
            setpoint_reg <= step_upd.setpoint;
        end
    end

    // pack the outgoing transaction
    assign m_tvalid       = out_valid_reg;
    assign m_tdata[15:0]  = out_result_reg.position;
    assign m_tdata[39:16] = out_result_reg.outlet_pressure;
    assign m_tdata[55:40] = out_result_reg.resistance_out;
    assign m_tuser        = out_result_reg.setpoint_error;

endmodule

`default_nettype wire

### hdl/rlva_step.sv
`default_nettype none

// one tick of the actuator: slew-limited position, outlet pressure, resistance
module rlva_step (
    input  wire rlva_pkg::item_t                 item,
    input  wire logic [rlva_pkg::POS_W-1:0]      cur_pos,
    input  wire logic [rlva_pkg::POS_W-1:0]      cur_setpoint,
    input  wire logic [rlva_pkg::POS_W-1:0]      step,
    input  wire logic [rlva_pkg::PRES_W-1:0]     min_pres,
    output rlva_pkg::result_t                    result,
    output rlva_pkg::state_upd_t                 upd
);

    localparam int POS_W  = rlva_pkg::POS_W;
    localparam int PRES_W = rlva_pkg::PRES_W;
    localparam int FB     = rlva_pkg::FRAC_BITS;

    logic [POS_W-1:0]        sp;
    logic                    sp_bad;
    logic [POS_W:0]          up_sum;
    logic [POS_W:0]          dn_diff;
    logic [POS_W-1:0]        new_pos;
    logic [PRES_W+POS_W-1:0] pres_prod;
    logic [PRES_W-1:0]       pres_q;
    logic [2*POS_W-1:0]      res_prod;
    logic [POS_W-1:0]        open_part;

    always_comb
    begin
        sp      = item.hold_setpoint ? cur_setpoint : item.given_position;
        sp_bad  = sp > rlva_pkg::ONE;
        up_sum  = {1'b0, cur_pos} + {1'b0, step};
        dn_diff = {1'b0, cur_pos} - {1'b0, step};

        // move one step, snap onto the setpoint on overshoot
        if (sp > cur_pos)
        begin
            new_pos = (up_sum > {1'b0, sp}) ? sp : up_sum[POS_W-1:0];
        end
        else if (sp < cur_pos)
        begin
            new_pos = (dn_diff[POS_W] || (dn_diff[POS_W-1:0] < sp)) ? sp
                                                                   : dn_diff[POS_W-1:0];
        end
        else
        begin
            new_pos = cur_pos;
        end

        pres_prod = {{POS_W{1'b0}}, item.inlet_pressure} * {{PRES_W{1'b0}}, new_pos};
        pres_q    = pres_prod[FB +: PRES_W];

        res_prod  = {{POS_W{1'b0}}, rlva_pkg::ONE - item.resistance_in}
                  * {{POS_W{1'b0}}, new_pos};
        open_part = res_prod[FB +: POS_W];

        if (sp_bad)
        begin
            result.position        = cur_pos;
            result.outlet_pressure = '0;
            result.resistance_out  = '0;
            result.setpoint_error  = 1'b1;
        end
        else
        begin
            result.position        = new_pos;
            result.outlet_pressure = (pres_q < min_pres) ? min_pres : pres_q;
            result.resistance_out  = (item.resistance_in >= rlva_pkg::ONE)
                                   ? rlva_pkg::ONE : rlva_pkg::ONE - open_part;
            result.setpoint_error  = 1'b0;
        end

        upd.update   = !sp_bad;
        upd.position = new_pos;
        upd.setpoint = sp;
    end

endmodule

`default_nettype wire

### hdl/rlva_checker.sv
`default_nettype none

`include "rate_limited_valve_actuator_macros.svh"

// port-level checks on the actuator
module rlva_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [rlva_pkg::DATA_W-1:0]   m_tdata,
    input  wire logic                          m_tuser
);

    // an error result carries no pressure and no resistance
    `RLVA_ASSERT_COMB(a_err_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata[55:16] == '0)

    // position stays within fully closed to fully open
    `RLVA_ASSERT_COMB(a_pos_range, clk, rst_n, m_tvalid, m_tdata[15:0] <= rlva_pkg::ONE)

    // combined resistance never above one
    `RLVA_ASSERT_COMB(a_res_range, clk, rst_n, m_tvalid, m_tdata[55:40] <= rlva_pkg::ONE)

    // stalled result holds
    `RLVA_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind rate_limited_valve_actuator rlva_checker u_rlva_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
